// ----- design/dual_window_moving_average_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual-window moving average unit
// Short forms for the clocked checks, sampled on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_WINDOW_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define DUAL_WINDOW_MOVING_AVERAGE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DWMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- design/dwma_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual-window moving average package
// Sizes, channel codes, sequencer states and divider status shared by the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwma_pkg;

  // Ring depth and stored sample width.
  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned SAMPLE_BITS = 32;

  // Derived widths.
  localparam int unsigned IDX_W     = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W     = SAMPLE_BITS + FILL_W;
  localparam int unsigned RAM_AW    = IDX_W + 1;
  localparam int unsigned RAM_DEPTH = 2 * RING_DEPTH;

  // Fixed field widths of the interface.
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned WSIZE_W   = 11;
  localparam int unsigned OFILL_W   = 11;
  localparam int unsigned REQ_SUM_W = 64;
  localparam int unsigned REQ_CNT_W = 32;

  // Shared divider widths.
  localparam int unsigned DIVD_W = 64;
  localparam int unsigned DIVS_W = 32;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned WSIZE_RESET     = 1000;
  localparam logic        REG_WINDOW_SIZE = 1'b0;

  // Channel codes.
  localparam logic CH_FIRST   = 1'b0;
  localparam logic CH_BETWEEN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ_WAIT,
    ST_CHECK,
    ST_EVICT,
    ST_INSERT,
    ST_AVG_WAIT,
    ST_OUT_LOAD
  } dwma_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- design/dwma_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dwma_div.sv -----
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned divide, one quotient bit per cycle; quotient held until next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwma_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dwma_pkg::DIVD_W-1:0] dividend_i,
  input  logic [dwma_pkg::DIVS_W-1:0] divisor_i,
  output logic [dwma_pkg::DIVD_W-1:0] quotient_o,
  output dwma_pkg::div_status_t       status_o
);

  import dwma_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   trial;
  logic              qbit;

  // One restoring step: bring in the next dividend bit and try the subtract.
  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVD_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? DIVS_W'(trial - {1'b0, dvs_q}) : DIVS_W'(trial);
      quo_d = {quo_q[DIVD_W-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is loaded on start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ----- design/dual_window_moving_average_unit.sv -----
// ----------------------------------------------------------------------------
// Dual-window moving average unit
// Two sliding latency windows sharing one sample RAM and one serial divider.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_axis channel: tuser selects the window (0 for a
// first-token sample, 1 for a decode-time element), tdata carries the value
// and tlast marks the final decode element of a request. A first-token beat,
// and a decode beat with tlast set, each produce one result beat on m_axis:
// tuser names the window, tdata holds the window average and fill count.
// A decode beat without tlast is only accumulated and gives no result.
// Each result waits on the 64-step serial divider, used once for the window
// average and, for a closing decode beat, once more for the request mean.
// s_axis_tready is high only while the sequencer is idle, so one beat is in
// flight at a time. A finished result sits in an output register; a new input
// beat is taken while it waits, and the sequencer only holds before loading the
// next result if the receiver is still stalling. Reset empties both windows,
// clears the request accumulator and sets window_size to 1000; ring entries
// need no clear. The APB port writes window_size at address 0; the user must
// write it only while the unit is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_window_moving_average_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dwma_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // [31:0] sample_value
  input  logic                               s_axis_tuser,  // [0] channel
  input  logic                               s_axis_tlast,  // last_element
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [47:0]                        m_axis_tdata,  // [31:0] window_average,
                                                            // [42:32] window_fill
  output logic                               m_axis_tuser   // [0] out_channel
);

  import dwma_pkg::*;

`include "dual_window_moving_average_unit_assert.svh"

  dwma_state_e state_q, state_d;

  logic [WSIZE_W-1:0]     wsz_q;
  logic [IDX_W-1:0]       head_q [2];
  logic [IDX_W-1:0]       head_d [2];
  logic [FILL_W-1:0]      fill_q [2];
  logic [FILL_W-1:0]      fill_d [2];
  logic [SUM_W-1:0]       sum_q  [2];
  logic [SUM_W-1:0]       sum_d  [2];
  logic [REQ_SUM_W-1:0]   req_sum_q, req_sum_d, req_sum_nx;
  logic [REQ_CNT_W-1:0]   req_cnt_q, req_cnt_d, req_cnt_nx;
  logic                   ch_q, ch_d;
  logic [SAMPLE_BITS-1:0] smp_q, smp_d;

  logic                   out_valid_q;
  logic                   out_ch_q;
  logic [VALUE_W-1:0]     out_avg_q;
  logic [FILL_W-1:0]      out_fill_q;
  logic                   out_load;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [FILL_W-1:0]      limit;
  logic [FILL_W:0]        pos;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       head_nx;
  logic [SUM_W-1:0]       sum_ins;
  logic [FILL_W-1:0]      fill_ins;
  logic [SAMPLE_BITS-1:0] mean_sat;

  logic                   div_start;
  logic [DIVD_W-1:0]      div_dividend;
  logic [DIVS_W-1:0]      div_divisor;
  logic [DIVD_W-1:0]      div_quot;
  div_status_t            div_st;

  logic                   ram_en;
  logic                   ram_we;
  logic [RAM_AW-1:0]      ram_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Single config register: the user writes it only while idle; not enforced here.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {{(32 - WSIZE_W){1'b0}}, wsz_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsz_q <= WSIZE_W'(WSIZE_RESET);
    end else if (cfg_wr && paddr[2] == REG_WINDOW_SIZE) begin
      wsz_q <= pwdata[WSIZE_W-1:0];
    end
  end

  // Effective window: zero counts as one, large sizes saturate to the depth.
  always_comb begin
    if (wsz_q == '0) begin
      limit = FILL_W'(1);
    end else if (32'(wsz_q) > RING_DEPTH) begin
      limit = FILL_W'(RING_DEPTH);
    end else begin
      limit = FILL_W'(wsz_q);
    end
  end

  // Ring arithmetic for the selected window.
  assign pos      = {1'b0, FILL_W'(head_q[ch_q])} + {1'b0, fill_q[ch_q]};
  assign slot     = (32'(pos) >= RING_DEPTH) ? IDX_W'(32'(pos) - RING_DEPTH) : IDX_W'(pos);
  assign head_nx  = (32'(head_q[ch_q]) == RING_DEPTH - 1) ? '0 : head_q[ch_q] + IDX_W'(1);
  assign sum_ins  = sum_q[ch_q] + SUM_W'(smp_q);
  assign fill_ins = fill_q[ch_q] + FILL_W'(1);

  // Request accumulator: wrapping sum, saturating element count.
  assign req_sum_nx = req_sum_q + REQ_SUM_W'(s_axis_tdata);
  assign req_cnt_nx = (&req_cnt_q) ? req_cnt_q : req_cnt_q + REQ_CNT_W'(1);

  // Request mean clipped to the largest sample value.
  assign mean_sat = (|div_quot[DIVD_W-1:SAMPLE_BITS]) ? '1 : div_quot[SAMPLE_BITS-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Sequencer: next state, datapath updates, divider and RAM control.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    req_sum_d    = req_sum_q;
    req_cnt_d    = req_cnt_q;
    ch_d         = ch_q;
    smp_d        = smp_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = {ch_q, head_q[ch_q]};
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == CH_FIRST) begin
            ch_d    = CH_FIRST;
            smp_d   = s_axis_tdata[SAMPLE_BITS-1:0];
            state_d = ST_CHECK;
          end else if (s_axis_tlast) begin
            div_start    = 1'b1;
            div_dividend = DIVD_W'(req_sum_nx);
            div_divisor  = DIVS_W'(req_cnt_nx);
            req_sum_d    = '0;
            req_cnt_d    = '0;
            ch_d         = CH_BETWEEN;
            state_d      = ST_REQ_WAIT;
          end else begin
            req_sum_d = req_sum_nx;
            req_cnt_d = req_cnt_nx;
          end
        end
      end
      ST_REQ_WAIT: begin
        if (div_st.done) begin
          smp_d   = mean_sat;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A full window first reads its oldest sample back for removal.
        if (fill_q[ch_q] >= limit && fill_q[ch_q] != '0) begin
          ram_en  = 1'b1;
          state_d = ST_EVICT;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_EVICT: begin
        sum_d[ch_q]  = sum_q[ch_q] - SUM_W'(ram_rdata);
        head_d[ch_q] = head_nx;
        fill_d[ch_q] = fill_q[ch_q] - FILL_W'(1);
        state_d      = ST_INSERT;
      end
      ST_INSERT: begin
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = {ch_q, slot};
        sum_d[ch_q]  = sum_ins;
        fill_d[ch_q] = fill_ins;
        div_start    = 1'b1;
        div_dividend = DIVD_W'(sum_ins);
        div_divisor  = DIVS_W'(fill_ins);
        state_d      = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_st.done) begin
          state_d = ST_OUT_LOAD;
        end
      end
      ST_OUT_LOAD: begin
        // Load only once the previous result has gone.
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      sum_q       <= '{default: '0};
      req_sum_q   <= '0;
      req_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      req_sum_q   <= req_sum_d;
      req_cnt_q   <= req_cnt_d;
      out_valid_q <= out_load | (out_valid_q & ~m_axis_tready);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q  <= ch_d;
    smp_q <= smp_d;
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_avg_q  <= div_quot[VALUE_W-1:0];
      out_fill_q <= fill_q[ch_q];
    end
  end

  // Result beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tdata  = {{(48 - VALUE_W - OFILL_W){1'b0}}, OFILL_W'(out_fill_q), out_avg_q};

  // Shared divider for the request mean and the window average.
  dwma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .status_o   (div_st)
  );

  // Both rings share one RAM, the channel selecting the upper half.
  dwma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (smp_q),
    .rdata_o (ram_rdata)
  );

  // Checks on the sequencer and divider hand-off.
  `DWMA_ASSERT_IMP(a_ready_div_idle, s_axis_tready, !div_st.busy)
  `DWMA_ASSERT_IMP(a_done_when_waiting, div_st.done,
                   state_q == ST_REQ_WAIT || state_q == ST_AVG_WAIT)
  `DWMA_ASSERT_IMP(a_out_fill_range, m_axis_tvalid,
                   out_fill_q != '0 && 32'(out_fill_q) <= RING_DEPTH)
  `DWMA_ASSERT_NXT(a_last_starts_div,
                   in_acc && s_axis_tuser == CH_BETWEEN && s_axis_tlast, div_st.busy)

endmodule

// ----- verif/tb_dual_window_moving_average_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the dual-window moving average unit
// Drives first-token samples and decode-time requests into the unit through a
// bursty input stream and drains the results through a stalling receiver.
// A behavioural copy of both latency windows predicts every result, and each
// beat that leaves the unit is compared with the oldest prediction. The window
// size register is swept through zero, small, saturating and full-depth
// values between phases, with a longer run of first-token samples at the
// saturated size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dual_window_moving_average_unit;

  import dwma_pkg::*;

  // Register map and run shape.
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE = CFG_ADDR_W'(4 * REG_WINDOW_SIZE);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_WINDOW_SIZE + CFG_ADDR_W'(4);
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 600;
  localparam int HOLD_AFTER    = 60;
  localparam int NUM_PHASES    = 7;

  // Window size, number of beats and share of decode beats for each phase.
  localparam int PHASE_WSIZE [NUM_PHASES] = '{0, 1, 8, 32, 2047, 2, 1024};
  localparam int PHASE_BEATS [NUM_PHASES] = '{40, 40, 100, 150, 300, 100, 100};
  localparam int PHASE_DECODE_PCT [NUM_PHASES] = '{50, 50, 50, 50, 0, 60, 50};

  typedef struct packed {
    logic                channel;
    logic [VALUE_W-1:0]  average;
    logic [OFILL_W-1:0]  fill;
  } window_result_t;

  typedef struct packed {
    logic                channel;
    logic [VALUE_W-1:0]  value;
    logic                last;
    logic                typed;
    logic                has_result;
    logic [VALUE_W-1:0]  average;
    logic [OFILL_W-1:0]  fill;
  } stim_row_t;

  typedef enum int {RX_STEADY, RX_PATCHY, RX_SPARSE} rx_mode_e;

  // Directed beats at the reset window size. Rows with typed set carry their
  // expected result; the others are left to the predictor.
  localparam stim_row_t DIRECTED_ROWS [16] = '{
    '{CH_FIRST,   32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 11'd1},
    '{CH_FIRST,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 11'd2},
    '{CH_FIRST,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 11'd1},
    '{CH_BETWEEN, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 11'd2},
    '{CH_BETWEEN, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'h0000_0002, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_FIRST,   32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_FIRST,   32'h5555_5555, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_FIRST,   32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_BETWEEN, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 11'd0},
    '{CH_FIRST,   32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 11'd0}
  };

  // Unit ports.
  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // [31:0] sample_value
  logic                  s_axis_tuser;   // [0] channel
  logic                  s_axis_tlast;   // last_element
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;   // [31:0] window_average, [42:32] window_fill
  logic                  m_axis_tuser;   // [0] out_channel

  // Predicted state of both windows and the request accumulator.
  logic [SAMPLE_BITS-1:0] ring_samples [2][RING_DEPTH];
  logic [IDX_W-1:0]       ring_head [2];
  logic [FILL_W-1:0]      ring_fill [2];
  logic [63:0]            window_sum [2];
  logic [REQ_SUM_W-1:0]   decode_sum;
  logic [REQ_CNT_W-1:0]   decode_count;
  logic [WSIZE_W-1:0]     window_size_q;

  window_result_t expected_results [$];
  int fail_count   = 0;
  int results_seen = 0;
  int burst_left   = 0;

  dual_window_moving_average_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  initial begin
    #20ms;
    $display("FAIL dual_window_moving_average_unit");
    $finish;
  end

  // Adds one sample to a window, evicting the oldest once the window is full,
  // and returns the new truncated average and fill count.
  function automatic void commit_sample(input logic win, input logic [31:0] sample,
                                        output window_result_t res);
    int unsigned limit;
    int unsigned slot;
    logic [63:0] quotient;
    limit = (window_size_q == 0) ? 1 :
            (window_size_q > RING_DEPTH) ? RING_DEPTH : window_size_q;
    if (ring_fill[win] >= limit && ring_fill[win] > 0) begin
      window_sum[win] = window_sum[win] - ring_samples[win][ring_head[win]];
      ring_head[win]  = IDX_W'((ring_head[win] + 1) % RING_DEPTH);
      ring_fill[win]  = ring_fill[win] - FILL_W'(1);
    end
    slot = (ring_head[win] + ring_fill[win]) % RING_DEPTH;
    ring_samples[win][slot] = sample;
    window_sum[win] = window_sum[win] + {32'b0, sample};
    ring_fill[win]  = ring_fill[win] + FILL_W'(1);
    quotient    = window_sum[win] / ring_fill[win];
    res.channel = win;
    res.average = quotient[VALUE_W-1:0];
    res.fill    = ring_fill[win];
  endfunction

  // Works out the result of one accepted beat; returns 0 where none follows.
  function automatic bit predict_beat(input logic channel, input logic [31:0] value,
                                      input logic last, output window_result_t res);
    logic [63:0] mean;
    res = '0;
    if (channel == CH_FIRST) begin
      commit_sample(CH_FIRST, value, res);
      return 1'b1;
    end
    decode_sum = decode_sum + {32'b0, value};
    if (decode_count != '1) decode_count = decode_count + REQ_CNT_W'(1);
    if (!last) return 1'b0;
    mean = decode_sum / {32'b0, decode_count};
    if (mean > 64'h0000_0000_FFFF_FFFF) mean = 64'h0000_0000_FFFF_FFFF;
    decode_sum   = '0;
    decode_count = '0;
    commit_sample(CH_BETWEEN, mean[31:0], res);
    return 1'b1;
  endfunction

  // Latency values weighted towards the extremes and small numbers.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_WINDOW_SIZE) window_size_q = data[WSIZE_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Register read, checked against the predicted window size.
  task automatic check_window_size();
    logic [31:0] rd;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_WINDOW_SIZE;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[WSIZE_W-1:0] !== window_size_q) begin
      $error("window_size mismatch: expected %0d, actual %0d", window_size_q,
             rd[WSIZE_W-1:0]);
      fail_count++;
    end
  endtask

  // Offers one beat, pacing the sender in bursts, and predicts its result
  // once the beat is accepted.
  task automatic send_beat(input logic channel, input logic [31:0] value, input logic last,
                           output bit has_result, output window_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = $urandom;
        s_axis_tuser  = 1'($urandom_range(1));
        s_axis_tlast  = 1'($urandom_range(1));
      end
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tuser  = channel;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    has_result = predict_beat(channel, value, last, res);
  endtask

  // One random phase: single first-token samples mixed with whole requests.
  task automatic run_phase(input int n_beats, input int decode_pct);
    int sent;
    int len;
    bit has_result;
    window_result_t res;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(99) < decode_pct) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_beat(CH_BETWEEN, rand_value(), k == len - 1, has_result, res);
          if (has_result) expected_results.push_back(res);
        end
        sent += len;
      end else begin
        send_beat(CH_FIRST, rand_value(), 1'($urandom_range(1)), has_result, res);
        if (has_result) expected_results.push_back(res);
        sent++;
      end
    end
  endtask

  // Drops the input and waits until the unit has delivered everything and
  // any accumulating beat has long been absorbed.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Main sequence.
  initial begin
    bit has_result;
    window_result_t res;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CH_FIRST;
    s_axis_tlast  = 1'b0;
    window_size_q = WSIZE_W'(WSIZE_RESET);
    decode_sum    = '0;
    decode_count  = '0;
    for (int w = 0; w < 2; w++) begin
      ring_head[w]  = '0;
      ring_fill[w]  = '0;
      window_sum[w] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value, then the directed beats at that window size.
    check_window_size();
    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].channel, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last,
                has_result, res);
      if (DIRECTED_ROWS[i].typed) begin
        has_result = DIRECTED_ROWS[i].has_result;
        res        = '{DIRECTED_ROWS[i].channel, DIRECTED_ROWS[i].average,
                       DIRECTED_ROWS[i].fill};
      end
      if (has_result) expected_results.push_back(res);
    end
    drain();

    // A write to an unmapped address must leave the window size alone.
    apb_write(ADDR_UNMAPPED, $urandom);
    check_window_size();

    // Random phases over a sweep of window sizes; upper data bits are noise.
    for (int p = 0; p < NUM_PHASES; p++) begin
      apb_write(ADDR_WINDOW_SIZE, ($urandom & 32'hFFFF_F800) | PHASE_WSIZE[p]);
      check_window_size();
      run_phase(PHASE_BEATS[p], PHASE_DECODE_PCT[p]);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS dual_window_moving_average_unit");
    end else begin
      $display("FAIL dual_window_moving_average_unit");
    end
    $finish;
  end

  // Receiver: stalls on a changing pattern, with one long hold-off part way
  // through so that the unit backs up onto its input.
  initial begin
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    bit held;
    m_axis_tready = 1'b0;
    mode          = RX_STEADY;
    mode_left     = 0;
    hold_left     = 0;
    held          = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          RX_STEADY: m_axis_tready = 1'b1;
          RX_PATCHY: m_axis_tready = 1'($urandom_range(1));
          default:   m_axis_tready = ($urandom_range(4) == 0);
        endcase
      end
    end
  end

  // Result checker: every result beat against the oldest prediction.
  always @(posedge clk_i) begin
    window_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: out_channel %0d, window_average %h, window_fill %0d",
               m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32]);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (m_axis_tuser !== exp_res.channel) begin
          $error("out_channel mismatch: expected %0d, actual %0d", exp_res.channel,
                 m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[31:0] !== exp_res.average) begin
          $error("window_average mismatch: expected %h, actual %h", exp_res.average,
                 m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[42:32] !== exp_res.fill) begin
          $error("window_fill mismatch: expected %0d, actual %0d", exp_res.fill,
                 m_axis_tdata[42:32]);
          fail_count++;
        end
      end
    end
  end

endmodule
